### rtl/eigen_recomposition_3x3_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the spectral recomposition block
// Clocked, reset-qualified property wrappers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef EIGEN_RECOMPOSITION_3X3_MACROS_SVH
`define EIGEN_RECOMPOSITION_3X3_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ERC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ERC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/erc_pkg.sv
// ----------------------------------------------------------------------------
// erc_pkg
// Shared widths, types and helpers of the spectral recomposition block.
// ----------------------------------------------------------------------------
package erc_pkg;

    localparam int DIM    = 3;
    localparam int DATA_W = 32;              // Q2.30 word
    localparam int FRAC_W = 30;
    localparam int IDX_W  = 2;               // row / column index
    localparam int TADR_W = 4;               // index into the 3x3 product table
    localparam int OPA_W  = DATA_W + 2;      // V*lambda rounded, kept unsaturated
    localparam int PROD_W = OPA_W + DATA_W;  // full product
    localparam int RND_W  = PROD_W - FRAC_W - 1;  // rounded product, 35 bits
    localparam int ACC_W  = RND_W + 1;       // sum of three rounded terms

    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_W - 1);

    typedef logic [DIM-1:0][DATA_W-1:0] row_t;

    // Work tag that travels with each product through the shared unit
    typedef struct packed {
        logic              is_b;   // 0: V*lambda pass, 1: final product pass
        logic [IDX_W-1:0]  k;      // summation index
        logic [IDX_W-1:0]  col;    // result column
        logic [TADR_W-1:0] taddr;  // table address for the first pass
    } tag_t;

    function automatic logic [TADR_W-1:0] tidx(input logic [IDX_W-1:0] i,
                                               input logic [IDX_W-1:0] k);
        return TADR_W'(i) * TADR_W'(DIM) + TADR_W'(k);
    endfunction

endpackage

### rtl/erc_in_if.sv
// ----------------------------------------------------------------------------
// erc_in_if
// Input channel: one row of the eigenvector matrix plus its eigenvalue.
// ----------------------------------------------------------------------------
interface erc_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [erc_pkg::DATA_W-1:0]  vec_col0;
    logic signed [erc_pkg::DATA_W-1:0]  vec_col1;
    logic signed [erc_pkg::DATA_W-1:0]  vec_col2;
    logic signed [erc_pkg::DATA_W-1:0]  eigen_value;
    logic                               last_row;

    modport source (output valid, vec_col0, vec_col1, vec_col2, eigen_value, last_row,
                    input ready);
    modport sink   (input valid, vec_col0, vec_col1, vec_col2, eigen_value, last_row,
                    output ready);
endinterface

### rtl/erc_out_if.sv
// ----------------------------------------------------------------------------
// erc_out_if
// Output channel: one row of the rebuilt matrix with status bits.
// ----------------------------------------------------------------------------
interface erc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [erc_pkg::DATA_W-1:0]  out_col0;
    logic signed [erc_pkg::DATA_W-1:0]  out_col1;
    logic signed [erc_pkg::DATA_W-1:0]  out_col2;
    logic        [erc_pkg::IDX_W-1:0]   out_row;
    logic                               saturated;
    logic                               out_last;

    modport source (output valid, out_col0, out_col1, out_col2, out_row, saturated,
                    out_last, input ready);
    modport sink   (input valid, out_col0, out_col1, out_col2, out_row, saturated,
                    out_last, output ready);
endinterface

### rtl/erc_mulrnd.sv
// ----------------------------------------------------------------------------
// erc_mulrnd
// Shared multiplier with round-to-nearest (ties away from zero) by 2^30.
// ----------------------------------------------------------------------------
module erc_mulrnd (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              op_valid,
    input  logic signed [erc_pkg::OPA_W-1:0]  op_a,
    input  logic signed [erc_pkg::DATA_W-1:0] op_b,
    input  erc_pkg::tag_t                     op_tag,
    output logic                              res_valid,
    output logic signed [erc_pkg::RND_W-1:0]  res,
    output erc_pkg::tag_t                     res_tag,
    output logic                              busy
);

    logic                              prod_valid_reg;
    logic signed [erc_pkg::PROD_W-1:0] prod_reg;
    erc_pkg::tag_t                     prod_tag_reg;
    logic                              res_valid_reg;
    logic signed [erc_pkg::RND_W-1:0]  res_reg;
    erc_pkg::tag_t                     res_tag_reg;
    logic        [erc_pkg::PROD_W-1:0] bias_sum;

    // Floor of (p + half - sign) / 2^30 rounds ties away from zero
    assign bias_sum = prod_reg + erc_pkg::HALF
                    - erc_pkg::PROD_W'(prod_reg[erc_pkg::PROD_W-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= op_valid;
            res_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= erc_pkg::PROD_W'(op_a) * erc_pkg::PROD_W'(op_b);
        prod_tag_reg <= op_tag;
        res_reg      <= $signed(bias_sum[erc_pkg::FRAC_W+erc_pkg::RND_W-1:erc_pkg::FRAC_W]);
        res_tag_reg  <= prod_tag_reg;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign res_tag   = res_tag_reg;
    assign busy      = prod_valid_reg | res_valid_reg;

endmodule

### rtl/eigen_recomposition_3x3.sv
// ----------------------------------------------------------------------------
// eigen_recomposition_3x3
// Rebuilds a symmetric 3x3 matrix B = V * diag(lambda) * V^T in Q2.30.
// ----------------------------------------------------------------------------
// Each input word carries one row of V and the eigenvalue of the column with
// the same index. An ordinary row is taken and stored; a fourth
// or later row before the last mark is dropped. The row marked last starts
// the computation and the block stops taking words until the final result
// row has been handed to the output register. All products go through one
// shared 34x32 multiplier with a rounding stage: first nine products
// t[i][k] = round(V[i][k]*lambda[k]) fill a small table, then each result
// row takes nine products round(t[i][k]*V[j][k]), summed per column and
// saturated to Q2.30. The table pass ends with a drain of the multiplier
// pipeline before the result rows start, and each result row drains the
// pipeline before it is handed on. A result row waits in the output
// register while the next one is computed.
// ----------------------------------------------------------------------------
`include "eigen_recomposition_3x3_macros.svh"

module eigen_recomposition_3x3 (
    input logic     clk,
    input logic     rst_n,
    erc_in_if.sink  eig,
    erc_out_if.source mat
);

    localparam logic [2:0] ST_IDLE    = 3'd0;   // take input rows
    localparam logic [2:0] ST_T       = 3'd1;   // issue V*lambda products
    localparam logic [2:0] ST_DRAIN   = 3'd2;   // let the table pass finish
    localparam logic [2:0] ST_B       = 3'd3;   // issue products of one result row
    localparam logic [2:0] ST_ROWWAIT = 3'd4;   // finish row, hand to output

    localparam int DW = erc_pkg::DATA_W;
    localparam int IW = erc_pkg::IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(erc_pkg::DIM - 1);

    // Control state
    logic [2:0]     state_reg, state_next;
    logic [IW-1:0]  row_count_reg, row_count_next;   // holds DIM when full
    logic [IW-1:0]  cnt_o_reg, cnt_o_next;           // outer index i or j
    logic [IW-1:0]  cnt_k_reg, cnt_k_next;           // summation index
    logic [IW-1:0]  row_reg, row_next;               // result row in progress

    // Storage
    erc_pkg::row_t                  vec_mem [erc_pkg::DIM];
    logic [DW-1:0]                  val_mem [erc_pkg::DIM];
    logic [erc_pkg::OPA_W-1:0]      t_mem   [erc_pkg::DIM*erc_pkg::DIM];

    // Read stage
    erc_pkg::row_t                  vec_a_reg, vec_b_reg;
    logic [DW-1:0]                  val_rd_reg;
    logic [erc_pkg::OPA_W-1:0]      t_rd_reg;
    logic                           rd_valid_reg;
    erc_pkg::tag_t                  rd_tag_reg;
    logic [IW-1:0]                  addr_a;
    erc_pkg::tag_t                  iss_tag;
    logic                           issuing;

    // Shared unit
    logic signed [erc_pkg::OPA_W-1:0] op_a;
    logic signed [DW-1:0]             op_b;
    logic                             u_valid;
    logic signed [erc_pkg::RND_W-1:0] u_res;
    erc_pkg::tag_t                    u_tag;
    logic                             u_busy;
    logic                             pipe_busy;

    // Accumulate and staging
    logic signed [erc_pkg::ACC_W-1:0] acc_reg, acc_next, acc_base;
    logic                             clip;
    logic [DW-1:0]                    sat_val;
    logic [DW-1:0]                    stage_col_reg [erc_pkg::DIM];
    logic                             stage_sat_reg;

    // Output register
    logic                             out_valid_reg;
    logic [DW-1:0]                    out_col_reg [erc_pkg::DIM];
    logic [IW-1:0]                    out_row_reg;
    logic                             out_sat_reg;
    logic                             out_last_reg;

    logic in_take, out_free, load_out, store_row;

    assign in_take   = eig.valid && eig.ready;
    assign store_row = in_take && (row_count_reg != IW'(erc_pkg::DIM));
    assign out_free  = !out_valid_reg || mat.ready;
    assign pipe_busy = rd_valid_reg || u_busy;
    assign load_out  = (state_reg == ST_ROWWAIT) && !pipe_busy && out_free;
    assign issuing   = (state_reg == ST_T) || (state_reg == ST_B);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        row_count_next = row_count_reg;
        cnt_o_next     = cnt_o_reg;
        cnt_k_next     = cnt_k_reg;
        row_next       = row_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    if (store_row)
                        row_count_next = row_count_reg + IW'(1);
                    if (eig.last_row)
                    begin
                        row_count_next = '0;
                        cnt_o_next     = '0;
                        cnt_k_next     = '0;
                        state_next     = ST_T;
                    end
                end
            end
            ST_T, ST_B:
            begin
                // Walk k inside the outer index; leave after the last pair
                if (cnt_k_reg == LAST_IDX)
                begin
                    cnt_k_next = '0;
                    cnt_o_next = cnt_o_reg + IW'(1);
                    if (cnt_o_reg == LAST_IDX)
                    begin
                        cnt_o_next = '0;
                        state_next = (state_reg == ST_T) ? ST_DRAIN : ST_ROWWAIT;
                    end
                end
                else
                begin
                    cnt_k_next = cnt_k_reg + IW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    row_next   = '0;
                    state_next = ST_B;
                end
            end
            ST_ROWWAIT:
            begin
                if (load_out)
                begin
                    if (row_reg == LAST_IDX)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + IW'(1);
                        state_next = ST_B;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_count_reg <= '0;
            cnt_o_reg     <= '0;
            cnt_k_reg     <= '0;
            row_reg       <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_count_reg <= row_count_next;
            cnt_o_reg     <= cnt_o_next;
            cnt_k_reg     <= cnt_k_next;
            row_reg       <= row_next;
            rd_valid_reg  <= issuing;
        end
    end

    // ------------------------------------------------------------------
    // Memories: one write port, registered reads
    // ------------------------------------------------------------------
    assign addr_a = (state_reg == ST_T) ? cnt_o_reg : row_reg;

    always_comb
    begin
        iss_tag.is_b  = (state_reg == ST_B);
        iss_tag.k     = cnt_k_reg;
        iss_tag.col   = cnt_o_reg;
        iss_tag.taddr = erc_pkg::tidx(cnt_o_reg, cnt_k_reg);
    end

    always_ff @(posedge clk)
    begin
        if (store_row)
        begin
            vec_mem[row_count_reg] <= {eig.vec_col2, eig.vec_col1, eig.vec_col0};
            val_mem[row_count_reg] <= eig.eigen_value;
        end
        vec_a_reg  <= vec_mem[addr_a];
        vec_b_reg  <= vec_mem[cnt_o_reg];
        val_rd_reg <= val_mem[cnt_k_reg];
        rd_tag_reg <= iss_tag;
    end

    always_ff @(posedge clk)
    begin
        if (u_valid && !u_tag.is_b)
            t_mem[u_tag.taddr] <= u_res[erc_pkg::OPA_W-1:0];
        t_rd_reg <= t_mem[erc_pkg::tidx(row_reg, cnt_k_reg)];
    end

    // ------------------------------------------------------------------
    // Operand select and shared multiplier
    // ------------------------------------------------------------------
    always_comb
    begin
        if (rd_tag_reg.is_b)
        begin
            op_a = $signed(t_rd_reg);
            op_b = $signed(vec_b_reg[rd_tag_reg.k]);
        end
        else
        begin
            op_a = erc_pkg::OPA_W'($signed(vec_a_reg[rd_tag_reg.k]));
            op_b = $signed(val_rd_reg);
        end
    end

    erc_mulrnd u_mulrnd (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (rd_valid_reg),
        .op_a      (op_a),
        .op_b      (op_b),
        .op_tag    (rd_tag_reg),
        .res_valid (u_valid),
        .res       (u_res),
        .res_tag   (u_tag),
        .busy      (u_busy)
    );

    // ------------------------------------------------------------------
    // Accumulate three terms per entry, saturate on the third
    // ------------------------------------------------------------------
    assign acc_base = (u_tag.k == '0) ? '0 : acc_reg;
    assign acc_next = acc_base + erc_pkg::ACC_W'(u_res);
    // Clip when the bits above the Q2.30 sign do not all match it
    assign clip     = (acc_next[erc_pkg::ACC_W-1:DW-1] != '0)
                   && (acc_next[erc_pkg::ACC_W-1:DW-1] != '1);
    assign sat_val  = clip ? {acc_next[erc_pkg::ACC_W-1], {(DW-1){!acc_next[erc_pkg::ACC_W-1]}}}
                           : acc_next[DW-1:0];

    always_ff @(posedge clk)
    begin
        if (u_valid && u_tag.is_b)
        begin
            acc_reg <= acc_next;
            if (u_tag.k == LAST_IDX)
                stage_col_reg[u_tag.col] <= sat_val;
        end
        if (load_out)
        begin
            for (int c = 0; c < erc_pkg::DIM; c++)
                out_col_reg[c] <= stage_col_reg[c];
            out_row_reg  <= row_reg;
            out_sat_reg  <= stage_sat_reg;
            out_last_reg <= (row_reg == LAST_IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_sat_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop the flag once its row moves out; collect clips otherwise
            if (load_out)
                stage_sat_reg <= 1'b0;
            else if (u_valid && u_tag.is_b && (u_tag.k == LAST_IDX))
                stage_sat_reg <= stage_sat_reg | clip;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (mat.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign eig.ready     = (state_reg == ST_IDLE);
    assign mat.valid     = out_valid_reg;
    assign mat.out_col0  = $signed(out_col_reg[0]);
    assign mat.out_col1  = $signed(out_col_reg[1]);
    assign mat.out_col2  = $signed(out_col_reg[2]);
    assign mat.out_row   = out_row_reg;
    assign mat.saturated = out_sat_reg;
    assign mat.out_last  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ERC_ASSERT_NOW(a_idle_pipe_empty, clk, rst_n, rd_valid_reg, state_reg != ST_IDLE, "multiplier issued while taking input rows")
    `ERC_ASSERT_NEXT(a_row_count_moves, clk, rst_n, in_take && !eig.last_row, row_count_reg != '0, "ordinary row left row count at zero")
    `ERC_ASSERT_NOW(a_table_pass_phase, clk, rst_n, u_valid && !u_tag.is_b, (state_reg == ST_T) || (state_reg == ST_DRAIN), "table product outside the table pass")
    `ERC_ASSERT_NEXT(a_row_waits_for_slot, clk, rst_n, (state_reg == ST_ROWWAIT) && out_valid_reg && !mat.ready, state_reg == ST_ROWWAIT, "result row left while output slot full")

endmodule
